@@ src/sc2a_pkg.sv @@
// Shared types, scan code constants and the set 2 key table for the
// scan code to ASCII converter. No dependencies.
`timescale 1ns / 1ps

package sc2a_pkg;

    localparam int RING_DEPTH_DEF = 32;
    localparam int SCAN_W         = 8;
    localparam int CHAR_W         = 7;

    localparam logic [SCAN_W-1:0] CODE_BREAK  = 8'hf0;
    localparam logic [SCAN_W-1:0] CODE_EXTEND = 8'he0;
    localparam logic [SCAN_W-1:0] CODE_LSHIFT = 8'h12;
    localparam logic [SCAN_W-1:0] CODE_RSHIFT = 8'h59;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic latch;
        logic push;
        logic rd_en;
        logic decode;
        logic load_out;
    } sc2a_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic char_nz;
        logic out_free;
    } sc2a_sts_t;

    localparam logic [7:0] KEY_ROM_PLAIN [128] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h09,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h71,8'h31,8'h00,
        8'h00,8'h00,8'h7a,8'h73,8'h61,8'h77,8'h32,8'h00,
        8'h00,8'h63,8'h78,8'h64,8'h65,8'h34,8'h33,8'h00,
        8'h00,8'h20,8'h76,8'h66,8'h74,8'h72,8'h35,8'h00,
        8'h00,8'h6e,8'h62,8'h68,8'h67,8'h79,8'h36,8'h00,
        8'h00,8'h00,8'h6d,8'h6a,8'h75,8'h37,8'h38,8'h00,
        8'h00,8'h2c,8'h6b,8'h69,8'h6f,8'h30,8'h39,8'h00,
        8'h00,8'h2e,8'h2f,8'h6c,8'h3b,8'h70,8'h2d,8'h00,
        8'h00,8'h5c,8'h3a,8'h00,8'h40,8'h5e,8'h00,8'h00,
        8'h00,8'h00,8'h0d,8'h5b,8'h00,8'h5d,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,
        8'h00,8'h00,8'h5c,8'h1d,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h7f,8'h1f,8'h00,8'h1c,8'h1e,8'h1b,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    localparam logic [7:0] KEY_ROM_SHIFT [128] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h09,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h51,8'h21,8'h00,
        8'h00,8'h00,8'h5a,8'h53,8'h41,8'h57,8'h22,8'h00,
        8'h00,8'h43,8'h58,8'h44,8'h45,8'h24,8'h23,8'h00,
        8'h00,8'h20,8'h56,8'h46,8'h54,8'h52,8'h25,8'h00,
        8'h00,8'h4e,8'h42,8'h48,8'h47,8'h59,8'h26,8'h00,
        8'h00,8'h00,8'h4d,8'h4a,8'h55,8'h27,8'h28,8'h00,
        8'h00,8'h3c,8'h4b,8'h49,8'h4f,8'h00,8'h29,8'h00,
        8'h00,8'h3e,8'h3f,8'h4c,8'h2b,8'h50,8'h3d,8'h00,
        8'h00,8'h5f,8'h2a,8'h00,8'h60,8'h7e,8'h00,8'h00,
        8'h00,8'h00,8'h0d,8'h7b,8'h00,8'h7d,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,
        8'h00,8'h00,8'h7c,8'h1d,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h7f,8'h1f,8'h00,8'h1c,8'h1e,8'h1b,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    function automatic logic [CHAR_W-1:0] key_char(input logic shift,
                                                   input logic [6:0] code);
        logic [7:0] raw;
        raw = shift ? KEY_ROM_SHIFT[code] : KEY_ROM_PLAIN[code];
        return raw[CHAR_W-1:0];
    endfunction

endpackage

@@ src/sc2a_in_if.sv @@
// Input channel: one push or character request per transfer.
// Depends on sc2a_pkg for the scan byte width.
`timescale 1ns / 1ps

interface sc2a_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [sc2a_pkg::SCAN_W-1:0]  scan_code;

    modport source (output valid, action, scan_code, input ready);
    modport sink   (input valid, action, scan_code, output ready);
endinterface

@@ src/sc2a_out_if.sv @@
// Result channel: one result per accepted input item.
// Depends on sc2a_pkg for the character width.
`timescale 1ns / 1ps

interface sc2a_out_if;
    logic                         valid;
    logic                         ready;
    logic [sc2a_pkg::CHAR_W-1:0]  ascii_char;
    logic                         key_held;
    logic                         dropped;
    logic                         ring_empty;

    modport source (output valid, ascii_char, key_held, dropped, ring_empty, input ready);
    modport sink   (input valid, ascii_char, key_held, dropped, ring_empty, output ready);
endinterface

@@ src/sc2a_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sc2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/sc2a_ctrl.sv @@
// Controller state machine: sequences pushes, ring reads, decodes and the
// hand-off to the output register. Depends on sc2a_pkg.
`timescale 1ns / 1ps

module sc2a_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_action,
    input  sc2a_pkg::sc2a_sts_t  sts,
    output sc2a_pkg::sc2a_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_DECODE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = in_action ? ST_SCAN : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (sts.empty)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                // The empty check is done again in the scan state.
                state_next = sts.char_nz ? ST_FINISH : ST_SCAN;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/sc2a_dp.sv @@
// Datapath: scan byte ring, ring indices, key decoder flags and the output
// register. Depends on sc2a_pkg and sc2a_ram.
`timescale 1ns / 1ps

module sc2a_dp #(
    parameter int RING_DEPTH = sc2a_pkg::RING_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sc2a_pkg::sc2a_cmd_t         cmd,
    output sc2a_pkg::sc2a_sts_t         sts,
    input  logic [sc2a_pkg::SCAN_W-1:0] in_code,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [sc2a_pkg::CHAR_W-1:0] out_char,
    output logic                        out_held,
    output logic                        out_drop,
    output logic                        out_empty
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    logic [sc2a_pkg::SCAN_W-1:0] code_reg;
    logic [AW-1:0]               wr_idx_reg, wr_idx_next;
    logic [AW-1:0]               rd_idx_reg, rd_idx_next;
    logic                        brk_reg, brk_next;
    logic                        ext_reg, ext_next;
    logic                        lsh_reg, lsh_next;
    logic                        rsh_reg, rsh_next;
    logic                        held_reg, held_next;
    logic [sc2a_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                        drop_reg, drop_next;
    logic                        out_valid_reg;
    logic [sc2a_pkg::CHAR_W-1:0] out_char_reg;
    logic                        out_held_reg;
    logic                        out_drop_reg;
    logic                        out_empty_reg;

    logic [AW-1:0]               wr_slot;
    logic [AW-1:0]               rd_slot;
    logic                        full;
    logic                        ring_wr;
    logic [sc2a_pkg::SCAN_W-1:0] rd_data;
    logic [sc2a_pkg::CHAR_W-1:0] dec_char;

    assign wr_slot = (wr_idx_reg == LAST_SLOT) ? '0 : wr_idx_reg + 1'b1;
    assign rd_slot = (rd_idx_reg == LAST_SLOT) ? '0 : rd_idx_reg + 1'b1;
    assign full    = (wr_slot == rd_idx_reg);
    assign ring_wr = cmd.push && !full;

    sc2a_ram #(
        .WIDTH (sc2a_pkg::SCAN_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (wr_idx_reg),
        .wr_data (code_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // Set 2 decoder for the byte just read from the ring.
    always_comb
    begin
        dec_char  = '0;
        brk_next  = brk_reg;
        ext_next  = ext_reg;
        lsh_next  = lsh_reg;
        rsh_next  = rsh_reg;
        held_next = held_reg;
        if (cmd.decode)
        begin
            if (rd_data == sc2a_pkg::CODE_BREAK)
            begin
                brk_next = 1'b1;
            end
            else if (rd_data == sc2a_pkg::CODE_EXTEND)
            begin
                ext_next = 1'b1;
            end
            else
            begin
                if (rd_data == sc2a_pkg::CODE_LSHIFT)
                begin
                    if (!ext_reg)
                    begin
                        lsh_next = !brk_reg;
                    end
                end
                else if (rd_data == sc2a_pkg::CODE_RSHIFT)
                begin
                    if (!ext_reg)
                    begin
                        rsh_next = !brk_reg;
                    end
                end
                else if (!brk_reg)
                begin
                    // Codes with the top bit set have no table entry.
                    if (!rd_data[7])
                    begin
                        dec_char = sc2a_pkg::key_char(lsh_reg || rsh_reg, rd_data[6:0]);
                    end
                    held_next = 1'b1;
                end
                else
                begin
                    held_next = 1'b0;
                end
                brk_next = 1'b0;
                ext_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        wr_idx_next = ring_wr ? wr_slot : wr_idx_reg;
        rd_idx_next = cmd.decode ? rd_slot : rd_idx_reg;
        char_next   = char_reg;
        drop_next   = drop_reg;
        if (cmd.latch)
        begin
            char_next = '0;
            drop_next = 1'b0;
        end
        else if (cmd.push)
        begin
            drop_next = full;
        end
        else if (cmd.decode)
        begin
            char_next = dec_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            brk_reg       <= 1'b0;
            ext_reg       <= 1'b0;
            lsh_reg       <= 1'b0;
            rsh_reg       <= 1'b0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            brk_reg    <= brk_next;
            ext_reg    <= ext_next;
            lsh_reg    <= lsh_next;
            rsh_reg    <= rsh_next;
            held_reg   <= held_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            code_reg <= in_code;
        end
        char_reg <= char_next;
        drop_reg <= drop_next;
        if (cmd.load_out)
        begin
            out_char_reg  <= char_reg;
            out_held_reg  <= held_reg;
            out_drop_reg  <= drop_reg;
            out_empty_reg <= (rd_idx_reg == wr_idx_reg);
        end
    end

    assign sts.empty    = (rd_idx_reg == wr_idx_reg);
    assign sts.char_nz  = (dec_char != '0);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_held  = out_held_reg;
    assign out_drop  = out_drop_reg;
    assign out_empty = out_empty_reg;

endmodule

@@ src/ps2_scancode_to_ascii_fifo.sv @@
// Top level of the set 2 scan code to ASCII converter with a scan byte ring.
// Depends on sc2a_pkg, sc2a_in_if, sc2a_out_if, sc2a_ctrl, sc2a_dp and sc2a_ram.
`timescale 1ns / 1ps

// Each input transfer either pushes one raw scan byte into a ring of RING_DEPTH
// entries (at most RING_DEPTH-1 bytes are held; a push into a full ring is
// discarded and reported as dropped) or requests one character, which drains
// ring bytes until one decodes to a nonzero character or the ring is empty.
// Every input transfer yields exactly one result transfer. A push goes from the
// push state to the finish state. A request enters the scan state; for each ring
// byte it consumes, the scan state reads the ring RAM's registered read port and
// the decode state decodes the byte, and a decoded character goes on to the
// finish state without another empty check. One item is worked on at a
// time; the next item is accepted while a finished result waits in the output
// register. The ring RAM is not cleared at reset and needs no start-up time.
module ps2_scancode_to_ascii_fifo #(
    parameter int RING_DEPTH = sc2a_pkg::RING_DEPTH_DEF
) (
    input logic           clk,
    input logic           rst_n,
    sc2a_in_if.sink       scan,
    sc2a_out_if.source    result
);

    sc2a_pkg::sc2a_cmd_t cmd;
    sc2a_pkg::sc2a_sts_t sts;

    sc2a_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scan.valid),
        .in_action (scan.action),
        .sts       (sts),
        .cmd       (cmd)
    );

    sc2a_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_code   (scan.scan_code),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_char  (result.ascii_char),
        .out_held  (result.key_held),
        .out_drop  (result.dropped),
        .out_empty (result.ring_empty)
    );

    assign scan.ready = cmd.in_ready;

    // A new item is never taken in the cycle right after a transfer.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        scan.valid && scan.ready |=> !scan.ready)
        else $error("input taken while an item is in work");

    // A character only comes from a make code, which sets the held flag.
    a_char_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.ascii_char != '0) |-> result.key_held)
        else $error("character without key held");

    // A lost push carries no character.
    a_drop_char: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.dropped |-> (result.ascii_char == '0))
        else $error("dropped push with a character");

    // The output register is never loaded while its result is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result.valid || result.ready))
        else $error("result overwritten before transfer");

endmodule

@@ tb/tb_ps2_scancode_to_ascii_fifo.sv @@
// Self-checking testbench for ps2_scancode_to_ascii_fifo: a directed table and random
// key sequences go through the input channel, and a cycle-free predictor checks each result.
// Depends on sc2a_pkg, sc2a_in_if, sc2a_out_if and the converter top level.
`timescale 1ns / 1ps

module tb_ps2_scancode_to_ascii_fifo;

    localparam int  CLK_PERIOD   = 8;
    localparam int  RESET_CYCLES = 10;
    localparam int  RING_DEPTH   = sc2a_pkg::RING_DEPTH_DEF;
    localparam int  HOLD_CYCLES  = 150;
    localparam int  TAIL_CYCLES  = 100;
    localparam time TIMEOUT_NS   = 5_000_000;

    typedef enum logic {
        ACT_PUSH    = 1'b0,
        ACT_REQUEST = 1'b1
    } action_t;

    typedef struct packed {
        logic [sc2a_pkg::CHAR_W-1:0] ascii_char;
        logic                        key_held;
        logic                        dropped;
        logic                        ring_empty;
    } result_t;

    typedef struct packed {
        action_t     act;
        logic [7:0]  code;
        logic        typed;
        result_t     want;
    } dir_row_t;

    localparam result_t NO_CHECK = '0;

    // Set 2 character map, unshifted and shifted banks.
    localparam logic [7:0] PLAIN_CHARS [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h71, 8'h31, 8'h00,
        8'h00, 8'h00, 8'h7a, 8'h73, 8'h61, 8'h77, 8'h32, 8'h00,
        8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h00,
        8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h00,
        8'h00, 8'h6e, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'h00,
        8'h00, 8'h00, 8'h6d, 8'h6a, 8'h75, 8'h37, 8'h38, 8'h00,
        8'h00, 8'h2c, 8'h6b, 8'h69, 8'h6f, 8'h30, 8'h39, 8'h00,
        8'h00, 8'h2e, 8'h2f, 8'h6c, 8'h3b, 8'h70, 8'h2d, 8'h00,
        8'h00, 8'h5c, 8'h3a, 8'h00, 8'h40, 8'h5e, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h0d, 8'h5b, 8'h00, 8'h5d, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
        8'h00, 8'h00, 8'h5c, 8'h1d, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h7f, 8'h1f, 8'h00, 8'h1c, 8'h1e, 8'h1b, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFTED_CHARS [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h51, 8'h21, 8'h00,
        8'h00, 8'h00, 8'h5a, 8'h53, 8'h41, 8'h57, 8'h22, 8'h00,
        8'h00, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'h23, 8'h00,
        8'h00, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'h00,
        8'h00, 8'h4e, 8'h42, 8'h48, 8'h47, 8'h59, 8'h26, 8'h00,
        8'h00, 8'h00, 8'h4d, 8'h4a, 8'h55, 8'h27, 8'h28, 8'h00,
        8'h00, 8'h3c, 8'h4b, 8'h49, 8'h4f, 8'h00, 8'h29, 8'h00,
        8'h00, 8'h3e, 8'h3f, 8'h4c, 8'h2b, 8'h50, 8'h3d, 8'h00,
        8'h00, 8'h5f, 8'h2a, 8'h00, 8'h60, 8'h7e, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h0d, 8'h7b, 8'h00, 8'h7d, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
        8'h00, 8'h00, 8'h7c, 8'h1d, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h7f, 8'h1f, 8'h00, 8'h1c, 8'h1e, 8'h1b, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Directed rows. Only rows whose result is obvious carry a typed expectation;
    // the rest are checked against the predictor.
    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Request on an empty ring right after reset.
        '{ACT_REQUEST, 8'hff,                 1'b1, '{7'h00, 1'b0, 1'b0, 1'b1}},
        '{ACT_PUSH,    8'h1c,                 1'b1, '{7'h00, 1'b0, 1'b0, 1'b0}},
        '{ACT_REQUEST, 8'h00,                 1'b1, '{7'h61, 1'b1, 1'b0, 1'b1}},
        // Break of the same key clears the held flag and yields no character.
        '{ACT_PUSH,    sc2a_pkg::CODE_BREAK,  1'b1, '{7'h00, 1'b1, 1'b0, 1'b0}},
        '{ACT_PUSH,    8'h1c,                 1'b0, NO_CHECK},
        '{ACT_REQUEST, 8'h00,                 1'b1, '{7'h00, 1'b0, 1'b0, 1'b1}},
        // Left shift selects the shifted bank.
        '{ACT_PUSH,    sc2a_pkg::CODE_LSHIFT, 1'b0, NO_CHECK},
        '{ACT_PUSH,    8'h1c,                 1'b0, NO_CHECK},
        '{ACT_REQUEST, 8'h00,                 1'b0, NO_CHECK},
        // Release left shift, an extended shift that must be ignored, then right shift.
        '{ACT_PUSH,    sc2a_pkg::CODE_BREAK,  1'b0, NO_CHECK},
        '{ACT_PUSH,    sc2a_pkg::CODE_LSHIFT, 1'b0, NO_CHECK},
        '{ACT_PUSH,    sc2a_pkg::CODE_EXTEND, 1'b0, NO_CHECK},
        '{ACT_PUSH,    sc2a_pkg::CODE_LSHIFT, 1'b0, NO_CHECK},
        '{ACT_PUSH,    sc2a_pkg::CODE_RSHIFT, 1'b0, NO_CHECK},
        '{ACT_PUSH,    8'h16,                 1'b0, NO_CHECK},
        '{ACT_REQUEST, 8'h00,                 1'b0, NO_CHECK},
        // Codes past the table, an extended make code and the table ends.
        '{ACT_PUSH,    8'hff,                 1'b0, NO_CHECK},
        '{ACT_PUSH,    8'h80,                 1'b0, NO_CHECK},
        '{ACT_PUSH,    sc2a_pkg::CODE_EXTEND, 1'b0, NO_CHECK},
        '{ACT_PUSH,    8'h75,                 1'b0, NO_CHECK},
        '{ACT_PUSH,    8'h7f,                 1'b0, NO_CHECK},
        '{ACT_PUSH,    8'h00,                 1'b0, NO_CHECK},
        '{ACT_REQUEST, 8'h00,                 1'b0, NO_CHECK},
        '{ACT_REQUEST, 8'h5a,                 1'b0, NO_CHECK}
    };

    logic clk;
    logic rst_n;

    sc2a_in_if  scan_bus ();
    sc2a_out_if result_bus ();

    ps2_scancode_to_ascii_fifo #(
        .RING_DEPTH (RING_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan_bus),
        .result (result_bus)
    );

    // Predictor state.
    logic [7:0] ring_copy [RING_DEPTH];
    int         wr_ptr;
    int         rd_ptr;
    logic       break_seen;
    logic       extend_seen;
    logic       lshift_down;
    logic       rshift_down;
    logic       held;

    result_t    pending_results [$];
    result_t    observed;

    int  items_sent;
    int  results_checked;
    int  chars_seen;
    int  drops_seen;
    int  errors;
    bit  idle_on;
    bit  stall_on;
    bit  hold_req;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [sc2a_pkg::CHAR_W-1:0] decode_scan_byte(logic [7:0] code);
        logic [7:0] raw;
        raw = 8'h00;
        if (code == sc2a_pkg::CODE_BREAK)
        begin
            break_seen = 1'b1;
            return '0;
        end
        if (code == sc2a_pkg::CODE_EXTEND)
        begin
            extend_seen = 1'b1;
            return '0;
        end
        if (code == sc2a_pkg::CODE_LSHIFT)
        begin
            if (!extend_seen)
                lshift_down = !break_seen;
        end
        else if (code == sc2a_pkg::CODE_RSHIFT)
        begin
            if (!extend_seen)
                rshift_down = !break_seen;
        end
        else if (!break_seen)
        begin
            // Codes past the table still count as a key press, with no character.
            if (!code[7])
                raw = (lshift_down || rshift_down) ? SHIFTED_CHARS[code[6:0]]
                                                   : PLAIN_CHARS[code[6:0]];
            held = 1'b1;
        end
        else
            held = 1'b0;
        break_seen  = 1'b0;
        extend_seen = 1'b0;
        return raw[sc2a_pkg::CHAR_W-1:0];
    endfunction

    function automatic result_t decode_item(action_t act, logic [7:0] code);
        result_t r;
        int      nxt;
        r = '0;
        if (act == ACT_PUSH)
        begin
            nxt = (wr_ptr + 1) % RING_DEPTH;
            if (nxt == rd_ptr)
                r.dropped = 1'b1;
            else
            begin
                ring_copy[wr_ptr] = code;
                wr_ptr = nxt;
            end
        end
        else
        begin
            while (rd_ptr != wr_ptr && r.ascii_char == '0)
            begin
                r.ascii_char = decode_scan_byte(ring_copy[rd_ptr]);
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            end
        end
        r.key_held   = held;
        r.ring_empty = (rd_ptr == wr_ptr);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t ns, result %0d, %s: got 'h%0h, expected 'h%0h",
                 $time, results_checked, what, got, want);
        errors++;
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with nothing pending", got, 0);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got.ascii_char !== want.ascii_char)
            report_mismatch("ascii_char", got.ascii_char, want.ascii_char);
        if (got.key_held !== want.key_held)
            report_mismatch("key_held", got.key_held, want.key_held);
        if (got.dropped !== want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
        if (got.ring_empty !== want.ring_empty)
            report_mismatch("ring_empty", got.ring_empty, want.ring_empty);
        if (got.ascii_char != '0)
            chars_seen++;
        if (got.dropped)
            drops_seen++;
    endtask

    // Leaves valid high after the transfer; the next call either keeps it high or
    // lowers it for a gap.
    task automatic send_item(action_t act, logic [7:0] code, logic typed, result_t want);
        result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            scan_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        scan_bus.valid     <= 1'b1;
        scan_bus.action    <= act;
        scan_bus.scan_code <= code;
        do
            @(posedge clk);
        while (!scan_bus.ready);
        predicted = decode_item(act, code);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic push_byte(logic [7:0] code);
        send_item(ACT_PUSH, code, 1'b0, NO_CHECK);
    endtask

    task automatic request_char();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_item(ACT_REQUEST, junk, 1'b0, NO_CHECK);
    endtask

    function automatic logic [7:0] pick_scan_byte();
        int         roll;
        logic [7:0] b;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            b = 8'($urandom_range(0, 127));
        else if (roll < 65)
            b = sc2a_pkg::CODE_BREAK;
        else if (roll < 73)
            b = sc2a_pkg::CODE_EXTEND;
        else if (roll < 83)
            b = $urandom_range(0, 1) ? sc2a_pkg::CODE_LSHIFT : sc2a_pkg::CODE_RSHIFT;
        else
            b = 8'($urandom_range(128, 255));
        return b;
    endfunction

    // One well-formed key event: optional extend prefix, optional break, then the code.
    task automatic key_event();
        int         roll;
        logic [7:0] code;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            code = 8'($urandom_range(0, 127));
        else if (roll < 85)
            code = $urandom_range(0, 1) ? sc2a_pkg::CODE_LSHIFT : sc2a_pkg::CODE_RSHIFT;
        else
            code = 8'($urandom_range(128, 255));
        if ($urandom_range(0, 4) == 0)
            push_byte(sc2a_pkg::CODE_EXTEND);
        if ($urandom_range(0, 2) == 0)
            push_byte(sc2a_pkg::CODE_BREAK);
        push_byte(code);
    endtask

    task automatic random_block();
        int         mode;
        logic [7:0] noise;
        mode = $urandom_range(0, 99);
        if (mode < 60)
        begin
            key_event();
            if ($urandom_range(0, 2) == 0)
                request_char();
        end
        else if (mode < 72)
        begin
            noise = 8'($urandom_range(0, 255));
            send_item($urandom_range(0, 1) ? ACT_REQUEST : ACT_PUSH, noise, 1'b0, NO_CHECK);
        end
        else if (mode < 80)
        begin
            // Fill the ring so that later pushes may be dropped, then drain some.
            repeat ($urandom_range(31, 36)) push_byte(pick_scan_byte());
            repeat ($urandom_range(2, 6)) request_char();
        end
        else if (mode < 92)
            request_char();
        else
        begin
            // Broken sequence: a dangling prefix before a request.
            push_byte($urandom_range(0, 1) ? sc2a_pkg::CODE_BREAK : sc2a_pkg::CODE_EXTEND);
            if ($urandom_range(0, 1) == 0)
                push_byte($urandom_range(0, 1) ? sc2a_pkg::CODE_BREAK
                                               : sc2a_pkg::CODE_EXTEND);
            request_char();
        end
    endtask

    task automatic run_until(int count);
        while (items_sent < count)
            random_block();
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            observed = {result_bus.ascii_char, result_bus.key_held,
                        result_bus.dropped, result_bus.ring_empty};
            check_result(observed);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still pending", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        scan_bus.valid     <= 1'b0;
        scan_bus.action    <= ACT_PUSH;
        scan_bus.scan_code <= 8'h00;
        wr_ptr          = 0;
        rd_ptr          = 0;
        break_seen      = 1'b0;
        extend_seen     = 1'b0;
        lshift_down     = 1'b0;
        rshift_down     = 1'b0;
        held            = 1'b0;
        items_sent      = 0;
        results_checked = 0;
        chars_seen      = 0;
        drops_seen      = 0;
        errors          = 0;
        idle_on         = 1'b1;
        stall_on        = 1'b1;
        hold_req        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].act, DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].want);

        run_until(DIR_ROWS + 250);

        // Results back up while the sender keeps offering, so the input stalls.
        hold_req = 1'b1;
        run_until(items_sent + 20);

        // Sender pause with every result in.
        scan_bus.valid <= 1'b0;
        wait_drained();
        repeat ($urandom_range(20, 50)) @(posedge clk);

        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_until(items_sent + 80);
        idle_on  = 1'b1;
        stall_on = 1'b1;
        run_until(items_sent + 200);
        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_until(items_sent + 150);

        scan_bus.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items and checked %0d results: %0d characters, %0d dropped pushes.",
                 items_sent, results_checked, chars_seen, drops_seen);
        $display("Stimulus mixed key sequences, ring overfills, noise, stalls and a long hold-off.");
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
